>>> rtl/core/lcdw_pkg.sv
// Shared constants, codes and command struct for the character LCD write core.
package lcdw_pkg;

   localparam int DISPLAY_CELLS = 80;
   localparam int LINE_CELLS    = 40;
   localparam int PATTERN_ROWS  = 64;

   localparam int CELL_W  = $clog2(DISPLAY_CELLS);
   localparam int PAT_W   = 6;
   localparam int DADDR_W = 7;
   localparam int BYTE_W  = 8;
   localparam int ROW_W   = 5;
   localparam int IDX_W   = 7;

   // operation codes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_RD_DISP = 2'd1;
   localparam logic [1:0] OP_RD_PAT  = 2'd2;

   // register select
   localparam logic RS_COMMAND = 1'b0;

   // command bytes and decode masks
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_HOME      = 8'h02;
   localparam logic [7:0] MASK_FUNC     = 8'he0;
   localparam logic [7:0] CODE_FUNC     = 8'h20;
   localparam logic [7:0] MASK_DISPCTL  = 8'hf8;
   localparam logic [7:0] CODE_DISPCTL  = 8'h08;
   localparam logic [7:0] MASK_ENTRY    = 8'hfc;
   localparam logic [7:0] CODE_ENTRY    = 8'h04;
   localparam logic [7:0] MASK_PATADDR  = 8'hc0;
   localparam logic [7:0] CODE_PATADDR  = 8'h40;

   localparam logic [7:0] BLANK_CHAR = 8'h20;

   typedef struct packed {
      logic load;   // capture request fields
      logic exec;   // apply the item to the state and stores
      logic fetch;  // read the stores into the result registers
   } dp_cmd_type;

endpackage

>>> rtl/core/lcdw_ctrl.sv
// Sequencing state machine for the character LCD write core.
module lcdw_ctrl
   import lcdw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_READ = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_READ;
         S_READ: state_in = S_RESP;
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   assign cmd.load  = req_valid && (state_ff == S_IDLE);
   assign cmd.exec  = (state_ff == S_EXEC);
   assign cmd.fetch = (state_ff == S_READ);

endmodule

>>> rtl/core/lcdw_datapath.sv
// Address counters, mode flags, clear sequencer and the display and pattern stores.
module lcdw_datapath
   import lcdw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  logic [1:0]         req_operation,
   input  logic               req_register_select,
   input  logic [BYTE_W-1:0]  req_bus_data,
   input  logic [IDX_W-1:0]   req_cell_index,
   output logic [BYTE_W-1:0]  rsp_read_value,
   output logic [DADDR_W-1:0] rsp_display_address,
   output logic [PAT_W-1:0]   rsp_pattern_address,
   output logic               rsp_target_is_display,
   output logic               rsp_increment_mode,
   output logic               rsp_shift_on_entry,
   output logic               rsp_display_on,
   output logic               rsp_cursor_on,
   output logic               rsp_blink_on,
   output logic               rsp_two_line,
   output logic               rsp_eight_bit_bus,
   output logic               rsp_tall_font
);

   // captured item
   logic [1:0]        op_ff;
   logic              rs_ff;
   logic [BYTE_W-1:0] data_ff;
   logic [IDX_W-1:0]  idx_ff;

   // state
   logic [DADDR_W-1:0] daddr_ff, daddr_in;
   logic [PAT_W-1:0]   paddr_ff, paddr_in;
   logic ddmode_ff, ddmode_in;
   logic id_ff, id_in;
   logic s_ff, s_in;
   logic d_ff, d_in;
   logic c_ff, c_in;
   logic b_ff, b_in;
   logic n_ff, n_in;
   logic dl_ff, dl_in;
   logic f_ff, f_in;
   logic              clr_busy_ff, clr_busy_in;
   logic [CELL_W-1:0] clr_idx_ff, clr_idx_in;

   // stores
   logic [BYTE_W-1:0]        disp_mem [DISPLAY_CELLS];
   logic [ROW_W-1:0]         pat_mem  [PATTERN_ROWS];
   logic [DISPLAY_CELLS-1:0] disp_vld_ff;
   logic [PATTERN_ROWS-1:0]  pat_vld_ff;

   logic              disp_we;
   logic [CELL_W-1:0] disp_wa;
   logic [BYTE_W-1:0] disp_wd;
   logic              pat_we;

   // read side
   logic [CELL_W-1:0] disp_ra;
   logic [PAT_W-1:0]  pat_ra;
   logic              disp_hit, pat_hit;
   logic              disp_hit_ff, pat_hit_ff;
   logic [BYTE_W-1:0] disp_q_ff;
   logic              disp_qv_ff;
   logic [ROW_W-1:0]  pat_q_ff;
   logic              pat_qv_ff;

   // address decode for display writes
   logic       bus_wr, cmd_wr, dat_wr;
   logic [7:0] off8, cell8;
   logic       cell_ok;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         rs_ff   <= req_register_select;
         data_ff <= req_bus_data;
         idx_ff  <= req_cell_index;
      end
   end

   // bus writes are dropped while a clear runs
   assign bus_wr = (op_ff == OP_WRITE) && !clr_busy_ff;
   assign cmd_wr = bus_wr && (rs_ff == RS_COMMAND);
   assign dat_wr = bus_wr && (rs_ff != RS_COMMAND);

   always_comb begin
      off8  = {2'b00, daddr_ff[5:0]};
      cell8 = n_ff ? off8 + (daddr_ff[6] ? 8'(LINE_CELLS) : 8'd0) : {1'b0, daddr_ff};
      cell_ok = (!n_ff || (off8 < 8'(LINE_CELLS))) && (cell8 < 8'(DISPLAY_CELLS));
   end

   always_comb begin
      daddr_in    = daddr_ff;
      paddr_in    = paddr_ff;
      ddmode_in   = ddmode_ff;
      id_in       = id_ff;
      s_in        = s_ff;
      d_in        = d_ff;
      c_in        = c_ff;
      b_in        = b_ff;
      n_in        = n_ff;
      dl_in       = dl_ff;
      f_in        = f_ff;
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (cmd.exec) begin
         if (clr_busy_ff) begin
            if (clr_idx_ff == CELL_W'(DISPLAY_CELLS - 1)) begin
               clr_busy_in = 1'b0;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         if (cmd_wr) begin
            if ((data_ff & MASK_FUNC) == CODE_FUNC) begin
               dl_in = data_ff[4];
               n_in  = data_ff[3];
               f_in  = data_ff[2];
            end else if ((data_ff & MASK_DISPCTL) == CODE_DISPCTL) begin
               d_in = data_ff[2];
               c_in = data_ff[1];
               b_in = data_ff[0];
            end else if (data_ff == CMD_CLEAR) begin
               daddr_in    = '0;
               id_in       = 1'b1;
               clr_busy_in = 1'b1;
               clr_idx_in  = '0;
            end else if (data_ff == CMD_HOME) begin
               daddr_in = '0;
            end else if ((data_ff & MASK_ENTRY) == CODE_ENTRY) begin
               id_in = data_ff[1];
               s_in  = data_ff[0];
            end else if ((data_ff & MASK_PATADDR) == CODE_PATADDR) begin
               paddr_in  = data_ff[PAT_W-1:0];
               ddmode_in = 1'b0;
            end else if (data_ff[7]) begin
               daddr_in  = data_ff[DADDR_W-1:0];
               ddmode_in = 1'b1;
            end
         end else if (dat_wr) begin
            // step the active address counter; wrap is natural at its width
            if (ddmode_ff) begin
               daddr_in = id_ff ? daddr_ff + 1'b1 : daddr_ff - 1'b1;
            end else begin
               paddr_in = id_ff ? paddr_ff + 1'b1 : paddr_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         daddr_ff    <= '0;
         paddr_ff    <= '0;
         ddmode_ff   <= 1'b0;
         id_ff       <= 1'b1;
         s_ff        <= 1'b0;
         d_ff        <= 1'b0;
         c_ff        <= 1'b0;
         b_ff        <= 1'b0;
         n_ff        <= 1'b0;
         dl_ff       <= 1'b0;
         f_ff        <= 1'b0;
         clr_busy_ff <= 1'b0;
         clr_idx_ff  <= '0;
      end else begin
         daddr_ff    <= daddr_in;
         paddr_ff    <= paddr_in;
         ddmode_ff   <= ddmode_in;
         id_ff       <= id_in;
         s_ff        <= s_in;
         d_ff        <= d_in;
         c_ff        <= c_in;
         b_ff        <= b_in;
         n_ff        <= n_in;
         dl_ff       <= dl_in;
         f_ff        <= f_in;
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // one display write per item: the clear fill or a data byte
   always_comb begin
      if (clr_busy_ff) begin
         disp_we = cmd.exec;
         disp_wa = clr_idx_ff;
         disp_wd = BLANK_CHAR;
      end else begin
         disp_we = cmd.exec && dat_wr && ddmode_ff && cell_ok;
         disp_wa = cell8[CELL_W-1:0];
         disp_wd = data_ff;
      end
   end

   assign pat_we = cmd.exec && dat_wr && !ddmode_ff;

   always_ff @(posedge clock) begin
      if (disp_we) begin
         disp_mem[disp_wa] <= disp_wd;
      end
      if (pat_we) begin
         pat_mem[paddr_ff] <= data_ff[ROW_W-1:0];
      end
   end

   // an entry never written reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_vld_ff <= '0;
         pat_vld_ff  <= '0;
      end else begin
         if (disp_we) disp_vld_ff[disp_wa] <= 1'b1;
         if (pat_we)  pat_vld_ff[paddr_ff] <= 1'b1;
      end
   end

   assign disp_ra  = idx_ff[CELL_W-1:0];
   assign pat_ra   = idx_ff[PAT_W-1:0];
   assign disp_hit = (op_ff == OP_RD_DISP) && ({1'b0, idx_ff} < 8'(DISPLAY_CELLS));
   assign pat_hit  = (op_ff == OP_RD_PAT) && (idx_ff < IDX_W'(PATTERN_ROWS));

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         disp_q_ff   <= disp_mem[disp_ra];
         disp_qv_ff  <= disp_vld_ff[disp_ra];
         pat_q_ff    <= pat_mem[pat_ra];
         pat_qv_ff   <= pat_vld_ff[pat_ra];
         disp_hit_ff <= disp_hit;
         pat_hit_ff  <= pat_hit;
      end
   end

   always_comb begin
      if (disp_hit_ff) begin
         rsp_read_value = disp_qv_ff ? disp_q_ff : BLANK_CHAR;
      end else if (pat_hit_ff) begin
         rsp_read_value = pat_qv_ff ? {3'b000, pat_q_ff} : '0;
      end else begin
         rsp_read_value = '0;
      end
   end

   assign rsp_display_address   = daddr_ff;
   assign rsp_pattern_address   = paddr_ff;
   assign rsp_target_is_display = ddmode_ff;
   assign rsp_increment_mode    = id_ff;
   assign rsp_shift_on_entry    = s_ff;
   assign rsp_display_on        = d_ff;
   assign rsp_cursor_on         = c_ff;
   assign rsp_blink_on          = b_ff;
   assign rsp_two_line          = n_ff;
   assign rsp_eight_bit_bus     = dl_ff;
   assign rsp_tall_font         = f_ff;

endmodule

>>> rtl/core/char_lcd_controller_write_core.sv
// Character LCD controller write core: top level joining controller and datapath.
//
// Request channel (req_*): one item per bus write or store read. operation
// selects a bus write (command or data register by register_select), a
// display cell read or a pattern row read at cell_index.
// Result channel (rsp_*): exactly one item per request, carrying the byte
// read (zero for writes) and the address counters and mode flags as they
// stand after the request.
// Timing: req_ready is high only while the core is idle. An accepted item
// passes through an update state (state and stores) and then a read state
// (registered store read) before rsp_valid rises; the core is ready again
// the cycle after the result is taken, so a new item is taken only once
// the result of the last one has been taken.
// A clear command arms a fill that blanks one display cell per following
// item, 80 items in all; bus writes in that window are dropped, reads are
// served and see the partly filled store.
// Reset (synchronous, active high): display cells read as spaces, pattern
// rows as zero, counters zero, increment mode set, no clear pending.
// While rsp_ready is low the result is held and no new item is taken.
module char_lcd_controller_write_core
   import lcdw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic               req_register_select,
   input  logic [BYTE_W-1:0]  req_bus_data,
   input  logic [IDX_W-1:0]   req_cell_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_read_value,
   output logic [DADDR_W-1:0] rsp_display_address,
   output logic [PAT_W-1:0]   rsp_pattern_address,
   output logic               rsp_target_is_display,
   output logic               rsp_increment_mode,
   output logic               rsp_shift_on_entry,
   output logic               rsp_display_on,
   output logic               rsp_cursor_on,
   output logic               rsp_blink_on,
   output logic               rsp_two_line,
   output logic               rsp_eight_bit_bus,
   output logic               rsp_tall_font
);

   dp_cmd_type cmd;

   lcdw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   lcdw_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_operation         (req_operation),
      .req_register_select   (req_register_select),
      .req_bus_data          (req_bus_data),
      .req_cell_index        (req_cell_index),
      .rsp_read_value        (rsp_read_value),
      .rsp_display_address   (rsp_display_address),
      .rsp_pattern_address   (rsp_pattern_address),
      .rsp_target_is_display (rsp_target_is_display),
      .rsp_increment_mode    (rsp_increment_mode),
      .rsp_shift_on_entry    (rsp_shift_on_entry),
      .rsp_display_on        (rsp_display_on),
      .rsp_cursor_on         (rsp_cursor_on),
      .rsp_blink_on          (rsp_blink_on),
      .rsp_two_line          (rsp_two_line),
      .rsp_eight_bit_bus     (rsp_eight_bit_bus),
      .rsp_tall_font         (rsp_tall_font)
   );

endmodule

>>> verif/lcdw_result_checker.sv
// Result checker for the LCD write core: predicts every result from accepted requests.
module lcdw_result_checker
   import lcdw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic               req_register_select,
   input  logic [BYTE_W-1:0]  req_bus_data,
   input  logic [IDX_W-1:0]   req_cell_index,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [BYTE_W-1:0]  rsp_read_value,
   input  logic [DADDR_W-1:0] rsp_display_address,
   input  logic [PAT_W-1:0]   rsp_pattern_address,
   input  logic               rsp_target_is_display,
   input  logic               rsp_increment_mode,
   input  logic               rsp_shift_on_entry,
   input  logic               rsp_display_on,
   input  logic               rsp_cursor_on,
   input  logic               rsp_blink_on,
   input  logic               rsp_two_line,
   input  logic               rsp_eight_bit_bus,
   input  logic               rsp_tall_font,
   output int                 mismatches,
   output int                 outstanding
);

   typedef struct packed {
      logic [BYTE_W-1:0]  read_value;
      logic [DADDR_W-1:0] display_address;
      logic [PAT_W-1:0]   pattern_address;
      logic               target_is_display;
      logic               increment_mode;
      logic               shift_on_entry;
      logic               display_on;
      logic               cursor_on;
      logic               blink_on;
      logic               two_line;
      logic               eight_bit_bus;
      logic               tall_font;
   } lcd_status_type;

   logic [BYTE_W-1:0]  char_cells [DISPLAY_CELLS];
   logic [ROW_W-1:0]   glyph_rows [PATTERN_ROWS];
   logic [DADDR_W-1:0] dd_addr;
   logic [PAT_W-1:0]   cg_addr;
   logic               bus8, lines2, font, disp, cursor, blink, inc, shift, dd_mode;
   int                 blank_left;
   lcd_status_type     status_q [$];

   function automatic void reset_model();
      for (int i = 0; i < DISPLAY_CELLS; i++) char_cells[i] = BLANK_CHAR;
      for (int i = 0; i < PATTERN_ROWS; i++) glyph_rows[i] = '0;
      dd_addr = '0;
      cg_addr = '0;
      {bus8, lines2, font, disp, cursor, blink, shift, dd_mode} = '0;
      inc = 1'b1;
      blank_left = 0;
   endfunction

   function automatic void apply_command(input logic [BYTE_W-1:0] cmd);
      if ((cmd & MASK_FUNC) == CODE_FUNC) begin
         {bus8, lines2, font} = cmd[4:2];
      end else if ((cmd & MASK_DISPCTL) == CODE_DISPCTL) begin
         {disp, cursor, blink} = cmd[2:0];
      end else if (cmd == CMD_CLEAR) begin
         dd_addr = '0;
         inc = 1'b1;
         blank_left = DISPLAY_CELLS;
      end else if (cmd == CMD_HOME) begin
         dd_addr = '0;
      end else if ((cmd & MASK_ENTRY) == CODE_ENTRY) begin
         {inc, shift} = cmd[1:0];
      end else if ((cmd & MASK_PATADDR) == CODE_PATADDR) begin
         cg_addr = cmd[5:0];
         dd_mode = 1'b0;
      end else if (cmd[7]) begin
         dd_addr = cmd[6:0];
         dd_mode = 1'b1;
      end
      // no-op and shift commands fall through untouched
   endfunction

   function automatic void apply_data(input logic [BYTE_W-1:0] data);
      int   cell_no;
      logic in_line;
      if (!dd_mode) begin
         glyph_rows[cg_addr] = data[ROW_W-1:0];
         cg_addr = inc ? cg_addr + 1'b1 : cg_addr - 1'b1;
      end else begin
         if (lines2) begin
            in_line = dd_addr[5:0] < LINE_CELLS;
            cell_no = dd_addr[5:0] + (dd_addr[6] ? LINE_CELLS : 0);
         end else begin
            in_line = 1'b1;
            cell_no = dd_addr;
         end
         // drop writes to cells that do not exist, but still step the address
         if (in_line && cell_no < DISPLAY_CELLS) char_cells[cell_no] = data;
         dd_addr = inc ? dd_addr + 1'b1 : dd_addr - 1'b1;
      end
   endfunction

   function automatic lcd_status_type predict_status(input logic [1:0] op, input logic rs,
                                                     input logic [BYTE_W-1:0] data,
                                                     input logic [IDX_W-1:0] idx);
      lcd_status_type s;
      logic           busy;
      s = '0;
      busy = 1'b0;
      if (blank_left != 0) begin
         char_cells[DISPLAY_CELLS - blank_left] = BLANK_CHAR;
         blank_left--;
         busy = 1'b1;
      end
      if (op == OP_WRITE) begin
         if (!busy) begin
            if (rs == RS_COMMAND) apply_command(data);
            else apply_data(data);
         end
      end else if (op == OP_RD_DISP) begin
         if (idx < DISPLAY_CELLS) s.read_value = char_cells[idx];
      end else if (op == OP_RD_PAT) begin
         if (idx < PATTERN_ROWS) s.read_value = glyph_rows[idx[PAT_W-1:0]];
      end
      s.display_address   = dd_addr;
      s.pattern_address   = cg_addr;
      s.target_is_display = dd_mode;
      s.increment_mode    = inc;
      s.shift_on_entry    = shift;
      s.display_on        = disp;
      s.cursor_on         = cursor;
      s.blink_on          = blink;
      s.two_line          = lines2;
      s.eight_bit_bus     = bus8;
      s.tall_font         = font;
      return s;
   endfunction

   function automatic int field_check(input string field, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
      if (want === got) return 0;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      return 1;
   endfunction

   function automatic int status_diff(input lcd_status_type want, input lcd_status_type got);
      return field_check("read_value", want.read_value, got.read_value)
           + field_check("display_address", want.display_address, got.display_address)
           + field_check("pattern_address", want.pattern_address, got.pattern_address)
           + field_check("target_is_display", want.target_is_display, got.target_is_display)
           + field_check("increment_mode", want.increment_mode, got.increment_mode)
           + field_check("shift_on_entry", want.shift_on_entry, got.shift_on_entry)
           + field_check("display_on", want.display_on, got.display_on)
           + field_check("cursor_on", want.cursor_on, got.cursor_on)
           + field_check("blink_on", want.blink_on, got.blink_on)
           + field_check("two_line", want.two_line, got.two_line)
           + field_check("eight_bit_bus", want.eight_bit_bus, got.eight_bit_bus)
           + field_check("tall_font", want.tall_font, got.tall_font);
   endfunction

   always @(posedge clock) begin : watch
      lcd_status_type got;
      if (reset) begin
         reset_model();
         status_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_read_value, rsp_display_address, rsp_pattern_address,
                   rsp_target_is_display, rsp_increment_mode, rsp_shift_on_entry,
                   rsp_display_on, rsp_cursor_on, rsp_blink_on, rsp_two_line,
                   rsp_eight_bit_bus, rsp_tall_font};
            if (status_q.size() == 0) begin
               $error("result item with no request outstanding");
               mismatches++;
            end else begin
               mismatches += status_diff(status_q.pop_front(), got);
            end
         end
         if (req_valid && req_ready)
            status_q.push_back(predict_status(req_operation, req_register_select,
                                              req_bus_data, req_cell_index));
      end
      outstanding <= status_q.size();
   end

endmodule

>>> verif/tb_top.sv
// Testbench top for the LCD write core: reset, request and result traffic, and the verdict.
module tb_top;
   import lcdw_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic       RS_DATA     = 1'b1;
   localparam logic [7:0] CMD_NONE    = 8'h00;
   localparam logic [7:0] CMD_SHIFT   = 8'h10;
   localparam logic [7:0] CMD_DDADDR  = 8'h80;
   localparam logic [7:0] FUNC_DL     = 8'h10;
   localparam logic [7:0] FUNC_N      = 8'h08;
   localparam logic [7:0] FUNC_F      = 8'h04;
   localparam logic [7:0] DISP_D      = 8'h04;
   localparam logic [7:0] DISP_C      = 8'h02;
   localparam logic [7:0] DISP_B      = 8'h01;
   localparam logic [7:0] ENTRY_ID    = 8'h02;
   localparam logic [7:0] ENTRY_S     = 8'h01;
   localparam logic [7:0] SHIFT_RIGHT = 8'h0c;
   localparam logic [6:0] LINE2_BASE  = 7'h40;
   localparam int RANDOM_ITEMS = 650;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 200000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_operation;
   logic               req_register_select;
   logic [BYTE_W-1:0]  req_bus_data;
   logic [IDX_W-1:0]   req_cell_index;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [BYTE_W-1:0]  rsp_read_value;
   logic [DADDR_W-1:0] rsp_display_address;
   logic [PAT_W-1:0]   rsp_pattern_address;
   logic               rsp_target_is_display;
   logic               rsp_increment_mode;
   logic               rsp_shift_on_entry;
   logic               rsp_display_on;
   logic               rsp_cursor_on;
   logic               rsp_blink_on;
   logic               rsp_two_line;
   logic               rsp_eight_bit_bus;
   logic               rsp_tall_font;
   int                 mismatches;
   int                 outstanding;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int counted = 0;     // items that reach the state, not ones dropped during a fill
   int fill_left = 0;
   int cycle_count;

   char_lcd_controller_write_core i_dut (.*);

   lcdw_result_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic send_item(input logic [1:0] op, input logic rs, input logic [7:0] data,
                            input logic [6:0] idx);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_register_select <= rs;
      req_bus_data        <= data;
      req_cell_index      <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // track the blanking window so writes swallowed by it are not counted
      if (fill_left != 0) begin
         if (op != OP_WRITE) counted++;
         fill_left--;
      end else begin
         counted++;
         if (op == OP_WRITE && rs == RS_COMMAND && data == CMD_CLEAR) fill_left = DISPLAY_CELLS;
      end
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [6:0] display_target();
      case ($urandom_range(3))
         0:       return 7'($urandom_range(LINE_CELLS - 1));
         1:       return LINE2_BASE + 7'($urandom_range(LINE_CELLS - 1));
         2:       return 7'($urandom_range(DISPLAY_CELLS - 1));
         default: return 7'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] random_command();
      logic [7:0] r;
      int         k;
      r = 8'($urandom);
      k = $urandom_range(99);
      if (k < 15) return CODE_FUNC | (r & ~MASK_FUNC);
      if (k < 27) return CODE_DISPCTL | (r & ~MASK_DISPCTL);
      if (k < 40) return CODE_ENTRY | (r & ~MASK_ENTRY);
      if (k < 55) return CODE_PATADDR | (r & ~MASK_PATADDR);
      if (k < 80) return CMD_DDADDR | {1'b0, display_target()};
      if (k < 84) return CMD_HOME;
      if (k < 85) return CMD_CLEAR;
      return r;
   endfunction

   function automatic logic [6:0] random_index();
      if ($urandom_range(3) == 0) return 7'($urandom);
      return 7'($urandom_range(DISPLAY_CELLS - 1));
   endfunction

   task automatic send_random();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40)
         send_item(OP_WRITE, RS_DATA, 8'($urandom), 7'($urandom));
      else if (pick < 65)
         send_item(OP_WRITE, RS_COMMAND, random_command(), 7'($urandom));
      else if (pick < 80)
         send_item(OP_RD_DISP, 1'($urandom), 8'($urandom), random_index());
      else if (pick < 95)
         send_item(OP_RD_PAT, 1'($urandom), 8'($urandom),
                   ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(PATTERN_ROWS - 1)));
      else
         send_item(OP_UNUSED, 1'($urandom), 8'($urandom), 7'($urandom));
   endtask

   // set an address, write a run of data, then read some of the stores back
   task automatic send_burst();
      if ($urandom_range(3) == 0)
         send_item(OP_WRITE, RS_COMMAND,
                   CODE_PATADDR | 8'($urandom_range(PATTERN_ROWS - 1)), 7'($urandom));
      else
         send_item(OP_WRITE, RS_COMMAND, CMD_DDADDR | {1'b0, display_target()}, 7'($urandom));
      repeat ($urandom_range(8, 2)) send_item(OP_WRITE, RS_DATA, 8'($urandom), 7'($urandom));
      repeat ($urandom_range(3, 1)) begin
         if ($urandom_range(1) == 0)
            send_item(OP_RD_DISP, 1'($urandom), 8'($urandom), random_index());
         else
            send_item(OP_RD_PAT, 1'($urandom), 8'($urandom),
                      7'($urandom_range(PATTERN_ROWS - 1)));
      end
   endtask

   task automatic run_random(input int goal);
      int stop;
      stop = counted + goal;
      while (counted < stop) begin
         if ($urandom_range(2) == 0) send_burst();
         else send_random();
      end
   endtask

   task automatic run_directed();
      // reset contents and out-of-range reads
      send_item(OP_RD_DISP, RS_COMMAND, 8'h00, 7'd0);
      send_item(OP_RD_DISP, RS_COMMAND, 8'h00, 7'h7f);
      send_item(OP_RD_PAT, RS_COMMAND, 8'h00, 7'(PATTERN_ROWS - 1));
      send_item(OP_RD_PAT, RS_COMMAND, 8'h00, 7'(PATTERN_ROWS));
      send_item(OP_UNUSED, RS_DATA, 8'hff, 7'h7f);
      // mode commands, all flags set, then the ignored ones
      send_item(OP_WRITE, RS_COMMAND, CODE_FUNC | FUNC_DL | FUNC_N | FUNC_F, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CODE_DISPCTL | DISP_D | DISP_C | DISP_B, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CODE_ENTRY | ENTRY_ID | ENTRY_S, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CMD_NONE, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CMD_SHIFT | SHIFT_RIGHT, 7'd0);
      // two-line mode: last cell of line one, then a hole address that is dropped
      send_item(OP_WRITE, RS_COMMAND, CMD_DDADDR | 8'(LINE_CELLS - 1), 7'd0);
      send_item(OP_WRITE, RS_DATA, 8'hff, 7'd0);
      send_item(OP_WRITE, RS_DATA, 8'h00, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CMD_DDADDR | {1'b0, LINE2_BASE + 7'(LINE_CELLS - 1)}, 7'd0);
      send_item(OP_WRITE, RS_DATA, 8'h5a, 7'd0);
      // count down: display address wraps below zero, pattern address too
      send_item(OP_WRITE, RS_COMMAND, CODE_ENTRY, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CMD_DDADDR, 7'd0);
      send_item(OP_WRITE, RS_DATA, 8'ha5, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CODE_PATADDR, 7'd0);
      send_item(OP_WRITE, RS_DATA, 8'hff, 7'd0);
      send_item(OP_RD_PAT, RS_DATA, 8'hff, 7'd0);
      send_item(OP_RD_DISP, RS_DATA, 8'hff, 7'(DISPLAY_CELLS - 1));
      // one-line mode: address past the last cell is dropped
      send_item(OP_WRITE, RS_COMMAND, CODE_FUNC, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CMD_DDADDR | 8'h7f, 7'd0);
      send_item(OP_WRITE, RS_DATA, 8'h33, 7'd0);
      send_item(OP_WRITE, RS_COMMAND, CMD_HOME, 7'd0);
      // clear: the next write is swallowed, reads see the partial fill
      send_item(OP_WRITE, RS_COMMAND, CMD_CLEAR, 7'd0);
      send_item(OP_WRITE, RS_DATA, 8'h41, 7'd0);
      send_item(OP_RD_DISP, RS_COMMAND, 8'h00, 7'(DISPLAY_CELLS - 1));
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("char_lcd_controller_write_core: mismatch");
      $finish;
   end

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_operation       <= OP_WRITE;
      req_register_select <= RS_COMMAND;
      req_bus_data        <= '0;
      req_cell_index      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_results();

      tx_idle_pct = 8;
      rx_idle_pct <= 59;
      run_random(RANDOM_ITEMS / 3);

      tx_idle_pct = 59;
      rx_idle_pct <= 8;
      holds_asked <= holds_asked + 1;
      run_random(RANDOM_ITEMS / 3);
      wait_results();

      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      wait_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("char_lcd_controller_write_core: match");
      else
         $display("char_lcd_controller_write_core: mismatch");
      $finish;
   end

endmodule
